@@ rtl/mic_pkg.sv @@
// Shared types, codes and constants of the masked interval coordinate mapper.
package mic_pkg;

    // Widths fixed by the item fields.
    localparam int POS_BITS = 20;
    localparam int LEN_BITS = POS_BITS + 1;
    localparam int MRL_BITS = 21;
    localparam int OPC_BITS = 3;

    // Default table depth.
    localparam int MAX_INTERVALS = 64;

    // Depth of the command queue between front and back; a power of two.
    localparam int QDEPTH = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    // Packed widths of the stream payloads.
    localparam int IN_DATA_BITS = 24;
    localparam int IN_USER_BITS = 3;
    localparam int OUT_DATA_BITS = 24;

    // Input operation codes.
    typedef enum logic [OPC_BITS-1:0] {
        OP_SYMBOL = 3'd0,
        OP_END    = 3'd1,
        OP_O2S    = 3'd2,
        OP_S2O    = 3'd3,
        OP_MASK   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MASKED    = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FINAL = 2'd3
    } status_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_EMIT
    } bk_state_t;

    // One classified command as it travels through the queue.
    typedef struct packed {
        op_t                 op;
        logic                masked;
        logic [POS_BITS-1:0] pos;
    } cmd_t;

    // One stored interval; the length is kept to save a subtract per step.
    typedef struct packed {
        logic [LEN_BITS-1:0] iv_len;
        logic [POS_BITS-1:0] iv_end;
        logic [POS_BITS-1:0] iv_start;
    } interval_t;

    localparam int IV_BITS = $bits(interval_t);

endpackage

@@ rtl/mic_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mic_front.sv @@
// Front end: accepts input items, classifies them and queues the commands.
module mic_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mic_pkg::IN_DATA_BITS-1:0]  s_data,
    input  logic [mic_pkg::IN_USER_BITS-1:0]  s_user,
    output logic                              q_valid,
    input  logic                              q_pop,
    output mic_pkg::cmd_t                     q_cmd
);

    mic_pkg::cmd_t                   entry_reg [mic_pkg::QDEPTH];
    logic [mic_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [mic_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [mic_pkg::QPTR_BITS:0]     cnt_reg;
    logic [mic_pkg::QPTR_BITS:0]     cnt_next;
    mic_pkg::cmd_t                   cmd;
    logic                            accept;
    logic                            keep;
    logic                            push;
    logic                            pop;

    assign s_ready = (cnt_reg != (mic_pkg::QPTR_BITS + 1)'(mic_pkg::QDEPTH));
    assign accept  = s_valid && s_ready;

    // Classify the item; unused opcodes are taken and dropped.
    always_comb
    begin
        cmd.op     = mic_pkg::op_t'(s_user[mic_pkg::OPC_BITS-1:0]);
        cmd.masked = s_data[0];
        cmd.pos    = s_data[mic_pkg::POS_BITS:1];
        case (s_user[mic_pkg::OPC_BITS-1:0])
            mic_pkg::OP_SYMBOL, mic_pkg::OP_END, mic_pkg::OP_O2S,
            mic_pkg::OP_S2O, mic_pkg::OP_MASK, mic_pkg::OP_CLEAR:
                keep = 1'b1;
            default:
                keep = 1'b0;
        endcase
    end

    assign push = accept && keep;
    assign pop  = q_pop && q_valid;

    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    // Queue occupancy.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

@@ rtl/mic_back.sv @@
// Back end: tracks runs, fills the interval table and walks it for queries.
module mic_back #(
    parameter int MAX_INTERVALS = mic_pkg::MAX_INTERVALS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mic_pkg::MRL_BITS-1:0]       cfg_wdata,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  mic_pkg::cmd_t                      q_cmd,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mic_pkg::OUT_DATA_BITS-1:0]  m_data
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int PB = mic_pkg::POS_BITS;
    localparam int LB = mic_pkg::LEN_BITS;

    // Sequencer and run tracking state.
    mic_pkg::bk_state_t           state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         in_run_reg, in_run_next;
    logic [PB-1:0]                run_start_reg, run_start_next;
    logic [LB-1:0]                run_len_reg, run_len_next;
    logic [LB-1:0]                seq_len_reg, seq_len_next;
    logic                         final_reg, final_next;
    logic                         ovf_reg, ovf_next;
    logic [mic_pkg::MRL_BITS-1:0] min_run_reg;
    logic [AW-1:0]                k_reg, k_next;
    logic                         m_valid_reg, m_valid_next;

    // Query working registers.
    mic_pkg::op_t                 op_reg, op_next;
    logic [PB-1:0]                pos_reg, pos_next;
    logic [LB-1:0]                acc_reg, acc_next;
    logic                         masked_reg, masked_next;
    mic_pkg::status_t             status_reg, status_next;
    logic [mic_pkg::OUT_DATA_BITS-1:0] m_data_reg, m_data_next;

    // Table access.
    logic                         wen;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;
    mic_pkg::interval_t           wentry;
    logic [mic_pkg::IV_BITS-1:0]  rdata;
    mic_pkg::interval_t           rentry;
    logic                         do_store;
    logic [PB-1:0]                store_end;
    logic                         hit;
    logic                         below;
    logic                         walk_done;
    logic                         last_entry;
    logic                         out_free;
    logic                         s2o_range;
    logic [PB-1:0]                out_pos;
    mic_pkg::status_t             out_status;

    mic_ram #(
        .WIDTH (mic_pkg::IV_BITS),
        .DEPTH (MAX_INTERVALS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (wen),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rentry     = mic_pkg::interval_t'(rdata);
    assign waddr      = count_reg[AW-1:0];
    assign wentry     = '{iv_len: run_len_reg, iv_end: store_end, iv_start: run_start_reg};
    assign raddr      = (state_reg == mic_pkg::BK_WALK) ? k_reg + AW'(1) : '0;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_entry = ((CW'(k_reg) + CW'(1)) == count_reg);

    // Interval comparisons for the entry read in this cycle.
    assign hit   = (pos_reg >= rentry.iv_start) && (pos_reg <= rentry.iv_end);
    assign below = (op_reg == mic_pkg::OP_S2O) ? (acc_reg < LB'(rentry.iv_start))
                                               : (pos_reg < rentry.iv_start);

    // A stripped-to-original result past the sequence end is out of range.
    assign s2o_range  = (op_reg == mic_pkg::OP_S2O) && (status_reg == mic_pkg::ST_OK)
                        && (acc_reg >= seq_len_reg);
    assign out_pos    = s2o_range ? '0 : acc_reg[PB-1:0];
    assign out_status = s2o_range ? mic_pkg::ST_RANGE : status_reg;

    // Next state, table writes and query steps.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        seq_len_next   = seq_len_reg;
        final_next     = final_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        m_valid_next   = m_valid_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        masked_next    = masked_reg;
        status_next    = status_reg;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;
        wen            = 1'b0;
        do_store       = 1'b0;
        store_end      = seq_len_reg[PB-1:0] - PB'(1);
        walk_done      = 1'b0;

        if (m_valid_reg && m_ready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mic_pkg::BK_IDLE:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    case (q_cmd.op)
                        mic_pkg::OP_SYMBOL:
                        begin
                            // Symbols past the position range are ignored.
                            if (!final_reg && !seq_len_reg[LB-1])
                            begin
                                if (q_cmd.masked)
                                begin
                                    if (!in_run_reg)
                                    begin
                                        run_start_next = seq_len_reg[PB-1:0];
                                        run_len_next   = LB'(1);
                                        in_run_next    = 1'b1;
                                    end
                                    else
                                    begin
                                        run_len_next = run_len_reg + LB'(1);
                                    end
                                end
                                else if (in_run_reg)
                                begin
                                    do_store    = 1'b1;
                                    in_run_next = 1'b0;
                                end
                                seq_len_next = seq_len_reg + LB'(1);
                            end
                        end
                        mic_pkg::OP_END:
                        begin
                            // An open run ends at the last symbol.
                            if (!final_reg)
                            begin
                                do_store    = in_run_reg;
                                in_run_next = 1'b0;
                                final_next  = 1'b1;
                            end
                        end
                        mic_pkg::OP_CLEAR:
                        begin
                            count_next     = '0;
                            in_run_next    = 1'b0;
                            run_start_next = '0;
                            run_len_next   = '0;
                            seq_len_next   = '0;
                            final_next     = 1'b0;
                            ovf_next       = 1'b0;
                        end
                        default:
                        begin
                            // Queries: settle early answers, else walk from entry zero.
                            op_next     = q_cmd.op;
                            pos_next    = q_cmd.pos;
                            masked_next = 1'b0;
                            status_next = mic_pkg::ST_OK;
                            acc_next    = (q_cmd.op == mic_pkg::OP_MASK) ? '0 : LB'(q_cmd.pos);
                            k_next      = '0;
                            if (!final_reg)
                            begin
                                status_next = mic_pkg::ST_NOT_FINAL;
                                acc_next    = '0;
                                state_next  = mic_pkg::BK_EMIT;
                            end
                            else if ((q_cmd.op == mic_pkg::OP_O2S)
                                     && (LB'(q_cmd.pos) >= seq_len_reg))
                            begin
                                status_next = mic_pkg::ST_RANGE;
                                acc_next    = '0;
                                state_next  = mic_pkg::BK_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = mic_pkg::BK_EMIT;
                            end
                            else
                            begin
                                state_next = mic_pkg::BK_WALK;
                            end
                        end
                    endcase
                end
            end
            mic_pkg::BK_WALK:
            begin
                // One stored interval per cycle, in ascending order.
                case (op_reg)
                    mic_pkg::OP_MASK:
                    begin
                        if (hit)
                        begin
                            masked_next = 1'b1;
                            walk_done   = 1'b1;
                        end
                        else if (below)
                        begin
                            walk_done = 1'b1;
                        end
                    end
                    mic_pkg::OP_O2S:
                    begin
                        if (hit)
                        begin
                            masked_next = 1'b1;
                            status_next = mic_pkg::ST_MASKED;
                            acc_next    = '0;
                            walk_done   = 1'b1;
                        end
                        else if (below)
                        begin
                            walk_done = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_reg - rentry.iv_len;
                        end
                    end
                    default:
                    begin
                        if (below)
                        begin
                            walk_done = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_reg + rentry.iv_len;
                        end
                    end
                endcase
                if (walk_done || last_entry)
                begin
                    state_next = mic_pkg::BK_EMIT;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            mic_pkg::BK_EMIT:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {ovf_reg, out_status, masked_reg, out_pos};
                    state_next   = mic_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mic_pkg::BK_IDLE;
            end
        endcase

        // Record a closed run that is long enough, or flag a full table.
        if (do_store && (run_len_reg >= min_run_reg))
        begin
            if (count_reg != CW'(MAX_INTERVALS))
            begin
                wen        = 1'b1;
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mic_pkg::BK_IDLE;
            count_reg     <= '0;
            in_run_reg    <= 1'b0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            seq_len_reg   <= '0;
            final_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            min_run_reg   <= mic_pkg::MRL_BITS'(1);
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            in_run_reg    <= in_run_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            seq_len_reg   <= seq_len_next;
            final_reg     <= final_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we)
            begin
                min_run_reg <= cfg_wdata;
            end
        end
    end

    // Query payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        acc_reg    <= acc_next;
        masked_reg <= masked_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/masked_interval_coordinate_mapper.sv @@
// Top level of the masked interval coordinate mapper.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: opcode; tdata: symbol_masked, position
//  m_axis    out        tdata: mapped_position, is_masked, status, table_overflow
//  cfg       in         cfg_wdata: min_run_length, written when cfg_we is high
//
// Symbol, end and clear items are handled in the back end's idle state; items
// with an unused opcode are dropped at the input and never reach the back end.
// A query answered at once goes from idle straight to emit; otherwise the back
// end first walks the stored intervals, one table read per cycle.
// A two-item command queue lets the input side run ahead of the back end.
// Reset clears the run tracker, the table count and the flags; table contents
// are not cleared. A stalled output holds its item and stalls the back end.
module masked_interval_coordinate_mapper #(
    parameter int MAX_INTERVALS = mic_pkg::MAX_INTERVALS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: [0] symbol_masked, [20:1] position, [23:21] zero
    input  logic [mic_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // tuser: [2:0] opcode
    input  logic [mic_pkg::IN_USER_BITS-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: [19:0] mapped_position, [20] is_masked, [22:21] status,
    //        [23] table_overflow
    output logic [mic_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [mic_pkg::MRL_BITS-1:0]       cfg_wdata
);

    logic          q_valid;
    logic          q_pop;
    mic_pkg::cmd_t q_cmd;

    mic_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd)
    );

    mic_back #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata)
    );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the masked interval coordinate mapper.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = mic_pkg::MAX_INTERVALS;
    localparam int WALK_BITS = mic_pkg::LEN_BITS + 1;
    localparam logic [mic_pkg::LEN_BITS-1:0] SEQ_CAP =
        mic_pkg::LEN_BITS'(1 << mic_pkg::POS_BITS);
    localparam logic [mic_pkg::MRL_BITS-1:0] MIN_RUN_TOP =
        mic_pkg::MRL_BITS'(1 << mic_pkg::POS_BITS);
    localparam logic [mic_pkg::OPC_BITS-1:0] OP_SPARE_LO =
        mic_pkg::OPC_BITS'(mic_pkg::OP_CLEAR + 1);
    localparam logic [mic_pkg::OPC_BITS-1:0] OP_SPARE_HI = '1;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 800;

    // One result item, laid out exactly as m_axis_tdata.
    typedef struct packed {
        logic                         ovf;
        mic_pkg::status_t             status;
        logic                         masked;
        logic [mic_pkg::POS_BITS-1:0] mapped;
    } result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [mic_pkg::IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic [mic_pkg::IN_USER_BITS-1:0]  s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [mic_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                              cfg_we = 1'b0;
    logic [mic_pkg::MRL_BITS-1:0]      cfg_wdata = 21'd1;

    // Mapper state as predicted by the testbench.
    logic [mic_pkg::POS_BITS-1:0] iv_lo [TABLE_DEPTH];
    logic [mic_pkg::POS_BITS-1:0] iv_hi [TABLE_DEPTH];
    int unsigned                  iv_count;
    bit                           run_open;
    logic [mic_pkg::POS_BITS-1:0] run_first;
    logic [mic_pkg::LEN_BITS-1:0] run_len;
    logic [mic_pkg::LEN_BITS-1:0] seq_len;
    bit                           sealed;
    bit                           dropped;
    logic [mic_pkg::MRL_BITS-1:0] min_run;

    result_t answers_due[$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      calm = 1'b0;
    int      stall_left = 0;

    masked_interval_coordinate_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Return the tracker and the table to their cleared state.
    function automatic void clear_model();
        iv_count  = 0;
        run_open  = 1'b0;
        run_first = '0;
        run_len   = '0;
        seq_len   = '0;
        sealed    = 1'b0;
        dropped   = 1'b0;
    endfunction

    // Store a closed run if it is long enough, or flag the drop when the table is full.
    function automatic void record_run(input logic [mic_pkg::POS_BITS-1:0] last);
        if (run_len < min_run)
            return;
        if (iv_count < TABLE_DEPTH)
        begin
            iv_lo[iv_count] = run_first;
            iv_hi[iv_count] = last;
            iv_count++;
        end
        else
            dropped = 1'b1;
    endfunction

    function automatic bit covered(input logic [mic_pkg::POS_BITS-1:0] p);
        for (int k = 0; k < iv_count; k++)
            if (p >= iv_lo[k] && p <= iv_hi[k])
                return 1'b1;
        return 1'b0;
    endfunction

    // Number of positions covered by stored interval k.
    function automatic logic [WALK_BITS-1:0] span(input int k);
        return WALK_BITS'(iv_hi[k]) - WALK_BITS'(iv_lo[k]) + WALK_BITS'(1);
    endfunction

    // Advance the predicted state by one item; returns 1 when the item yields a result.
    function automatic bit map_item(input logic [mic_pkg::OPC_BITS-1:0] op, input logic sym,
                                    input logic [mic_pkg::POS_BITS-1:0] pos,
                                    output result_t res);
        logic [WALK_BITS-1:0]         walk;
        logic [mic_pkg::POS_BITS-1:0] close_pos;
        res = '0;
        case (op)
            mic_pkg::OP_SYMBOL:
            begin
                if (!sealed && seq_len < SEQ_CAP)
                begin
                    if (sym)
                    begin
                        if (!run_open)
                        begin
                            run_first = seq_len[mic_pkg::POS_BITS-1:0];
                            run_len   = '0;
                            run_open  = 1'b1;
                        end
                        run_len++;
                    end
                    else if (run_open)
                    begin
                        close_pos = seq_len[mic_pkg::POS_BITS-1:0]
                                    - mic_pkg::POS_BITS'(1);
                        record_run(close_pos);
                        run_open = 1'b0;
                    end
                    seq_len++;
                end
                return 1'b0;
            end
            mic_pkg::OP_END:
            begin
                // An open run closes on the last symbol of the sequence.
                if (!sealed)
                begin
                    if (run_open && seq_len != 0)
                    begin
                        close_pos = seq_len[mic_pkg::POS_BITS-1:0]
                                    - mic_pkg::POS_BITS'(1);
                        record_run(close_pos);
                    end
                    run_open = 1'b0;
                    sealed   = 1'b1;
                end
                return 1'b0;
            end
            mic_pkg::OP_CLEAR:
            begin
                clear_model();
                return 1'b0;
            end
            mic_pkg::OP_O2S, mic_pkg::OP_S2O, mic_pkg::OP_MASK: ;
            default: return 1'b0;
        endcase

        res.ovf = dropped;
        if (!sealed)
            res.status = mic_pkg::ST_NOT_FINAL;
        else if (op == mic_pkg::OP_MASK)
            res.masked = covered(pos);
        else if (op == mic_pkg::OP_O2S)
        begin
            if (mic_pkg::LEN_BITS'(pos) >= seq_len)
                res.status = mic_pkg::ST_RANGE;
            else
            begin
                // Subtract every interval that lies wholly below the position.
                walk = WALK_BITS'(pos);
                for (int k = 0; k < iv_count; k++)
                begin
                    if (pos >= iv_lo[k] && pos <= iv_hi[k])
                    begin
                        res.status = mic_pkg::ST_MASKED;
                        res.masked = 1'b1;
                        walk = '0;
                        break;
                    end
                    if (pos < iv_lo[k])
                        break;
                    walk = walk - span(k);
                end
                res.mapped = walk[mic_pkg::POS_BITS-1:0];
            end
        end
        else
        begin
            // Stripped to original: skip over each interval at or below the running position.
            walk = WALK_BITS'(pos);
            for (int k = 0; k < iv_count; k++)
            begin
                if (walk < WALK_BITS'(iv_lo[k]))
                    break;
                walk = walk + span(k);
            end
            if (walk >= WALK_BITS'(seq_len))
                res.status = mic_pkg::ST_RANGE;
            else
                res.mapped = walk[mic_pkg::POS_BITS-1:0];
        end
        return 1'b1;
    endfunction

    // Offer one item, with an occasional idle burst ahead of it, and predict its result.
    task automatic send_item(input logic [mic_pkg::OPC_BITS-1:0] op, input logic sym,
                             input logic [mic_pkg::POS_BITS-1:0] pos);
        result_t res;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, pos, sym};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (map_item(op, sym, pos, res))
            answers_due = {answers_due, res};
        if (op <= mic_pkg::OP_CLEAR)
            items_sent++;
    endtask

    // Send one item of the given kind with random remaining fields.
    task automatic send_op(input logic [mic_pkg::OPC_BITS-1:0] op);
        send_item(op, 1'($urandom), mic_pkg::POS_BITS'($urandom));
    endtask

    task automatic send_run(input logic sym, input int count);
        repeat (count) send_item(mic_pkg::OP_SYMBOL, sym, mic_pkg::POS_BITS'($urandom));
    endtask

    // Wait until all results are in and the back end has worked off silent items.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_run(input logic [mic_pkg::MRL_BITS-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        min_run    = value;
    endtask

    task automatic random_query();
        logic [mic_pkg::POS_BITS-1:0] pos;
        logic [mic_pkg::OPC_BITS-1:0] op;
        case ($urandom_range(0, 2))
            0: op = mic_pkg::OP_O2S;
            1: op = mic_pkg::OP_S2O;
            default: op = mic_pkg::OP_MASK;
        endcase
        if ($urandom_range(0, 3) != 0)
            pos = mic_pkg::POS_BITS'($urandom_range(0, seq_len + 2));
        else
            pos = mic_pkg::POS_BITS'($urandom);
        send_item(op, 1'($urandom), pos);
    endtask

    // Mostly a clear, then a random sequence of runs, end of sequence, then queries; with some noise.
    task automatic random_sequence();
        int runs;
        bit dense;
        dense = ($urandom_range(0, 7) == 0);
        runs  = dense ? $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 16) : $urandom_range(0, 12);
        if ($urandom_range(0, 9) != 0)
            send_op(mic_pkg::OP_CLEAR);
        send_run(1'b0, $urandom_range(0, 3));
        for (int r = 0; r < runs; r++)
        begin
            send_run(1'b1, dense ? $urandom_range(1, 2) : $urandom_range(1, 9));
            if (r + 1 < runs || $urandom_range(0, 1) == 1)
                send_run(1'b0, dense ? 1 : $urandom_range(1, 5));
            if ($urandom_range(0, 19) == 0)
                send_op(mic_pkg::OPC_BITS'($urandom_range(0, OP_SPARE_HI)));
        end
        if ($urandom_range(0, 7) == 0)
            random_query();
        send_op(mic_pkg::OP_END);
        repeat ($urandom_range(8, 20))
        begin
            if ($urandom_range(0, 15) == 0)
                send_op(mic_pkg::OPC_BITS'($urandom_range(0, OP_SPARE_HI)));
            else
                random_query();
        end
    endtask

    // Queries before any end of sequence, then on an empty finished sequence.
    task automatic test_unsealed_and_empty();
        send_item(mic_pkg::OP_O2S, 1'b0, '0);
        send_item(mic_pkg::OP_S2O, 1'b1, '1);
        send_item(mic_pkg::OP_MASK, 1'b0, '1);
        send_item(mic_pkg::OP_END, 1'b0, '0);
        send_item(mic_pkg::OP_O2S, 1'b0, '0);
        send_item(mic_pkg::OP_S2O, 1'b0, '0);
        send_item(mic_pkg::OP_MASK, 1'b1, '0);
    endtask

    // Short runs below the minimum, an open final run, repeated end, and each query kind.
    task automatic test_runs_and_mapping();
        logic [11:0] pattern;
        pattern = 12'b1101_1100_1101;
        write_min_run(2);
        send_item(mic_pkg::OP_CLEAR, 1'b0, '0);
        for (int i = 0; i < 12; i++)
            send_item(mic_pkg::OP_SYMBOL, pattern[i], mic_pkg::POS_BITS'($urandom));
        send_item(mic_pkg::OP_O2S, 1'b0, 20'd5);
        send_item(mic_pkg::OP_END, 1'b0, '0);
        send_item(mic_pkg::OP_END, 1'b0, '0);
        send_item(mic_pkg::OP_SYMBOL, 1'b1, '0);
        send_item(mic_pkg::OP_O2S, 1'b0, 20'd1);
        send_item(mic_pkg::OP_O2S, 1'b0, 20'd5);
        send_item(mic_pkg::OP_O2S, 1'b0, 20'd11);
        send_item(mic_pkg::OP_O2S, 1'b0, 20'd12);
        send_item(mic_pkg::OP_O2S, 1'b0, '1);
        send_item(mic_pkg::OP_S2O, 1'b0, 20'd4);
        send_item(mic_pkg::OP_S2O, 1'b0, 20'd5);
        send_item(mic_pkg::OP_S2O, 1'b0, '1);
        send_item(mic_pkg::OP_MASK, 1'b0, 20'd11);
        send_item(mic_pkg::OP_MASK, 1'b0, '1);
        send_item(OP_SPARE_LO, 1'b1, '1);
        send_item(OP_SPARE_HI, 1'b0, '0);
        send_item(mic_pkg::OP_CLEAR, 1'b0, '0);
        send_item(mic_pkg::OP_MASK, 1'b0, 20'd11);
    endtask

    // More qualifying runs than the table holds; clear must drop the sticky flag.
    task automatic test_table_overflow();
        write_min_run(1);
        send_item(mic_pkg::OP_CLEAR, 1'b0, '0);
        repeat (TABLE_DEPTH + 2)
        begin
            send_item(mic_pkg::OP_SYMBOL, 1'b1, mic_pkg::POS_BITS'($urandom));
            send_item(mic_pkg::OP_SYMBOL, 1'b0, mic_pkg::POS_BITS'($urandom));
        end
        send_item(mic_pkg::OP_END, 1'b0, '0);
        send_item(mic_pkg::OP_MASK, 1'b0, mic_pkg::POS_BITS'(2 * TABLE_DEPTH - 2));
        send_item(mic_pkg::OP_MASK, 1'b0, mic_pkg::POS_BITS'(2 * TABLE_DEPTH));
        send_item(mic_pkg::OP_O2S, 1'b0, mic_pkg::POS_BITS'(2 * TABLE_DEPTH + 1));
        send_item(mic_pkg::OP_S2O, 1'b0, mic_pkg::POS_BITS'(TABLE_DEPTH + 1));
        send_item(mic_pkg::OP_CLEAR, 1'b0, '0);
        send_item(mic_pkg::OP_O2S, 1'b0, '0);
    endtask

    // At the largest minimum length the short masked run sent here does not qualify, so nothing is stored.
    task automatic test_largest_minimum();
        write_min_run(MIN_RUN_TOP);
        send_item(mic_pkg::OP_CLEAR, 1'b0, '0);
        send_run(1'b1, 40);
        send_item(mic_pkg::OP_END, 1'b0, '0);
        send_item(mic_pkg::OP_MASK, 1'b0, '0);
        send_item(mic_pkg::OP_MASK, 1'b0, '1);
        send_item(mic_pkg::OP_O2S, 1'b0, 20'd5);
        send_item(mic_pkg::OP_O2S, 1'b0, '1);
        send_item(mic_pkg::OP_S2O, 1'b0, '0);
        send_item(mic_pkg::OP_S2O, 1'b0, 20'd40);
    endtask

    // Random sequences under a rotating set of minimum run lengths.
    task automatic test_random_traffic();
        logic [mic_pkg::MRL_BITS-1:0] setting;
        int phase;
        phase = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase % 6)
                0: setting = mic_pkg::MRL_BITS'(1);
                1: setting = MIN_RUN_TOP;
                2: setting = mic_pkg::MRL_BITS'(2);
                3: setting = mic_pkg::MRL_BITS'($urandom_range(3, 9));
                4: setting = mic_pkg::MRL_BITS'($urandom_range(1, MIN_RUN_TOP));
                default: setting = mic_pkg::MRL_BITS'($urandom_range(1, 4));
            endcase
            write_min_run(setting);
            repeat (2)
            begin
                random_sequence();
                calm = (items_sent > RANDOM_ITEMS * 4 / 5);
            end
            phase++;
        end
    endtask

    // Result checking and output stall bursts.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        got = m_axis_tdata;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result mapped=%0d masked=%0b status=%0d ovf=%0b",
                         $time, got.mapped, got.masked, got.status, got.ovf);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: expected mapped=%0d masked=%0b status=%0d ovf=%0b,",
                             $time, want.mapped, want.masked, want.status, want.ovf);
                    $display("    got mapped=%0d masked=%0b status=%0d ovf=%0b",
                             got.mapped, got.masked, got.status, got.ovf);
                end
            end
        end
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Test sequence.
    initial
    begin
        clear_model();
        min_run = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_unsealed_and_empty();
        test_runs_and_mapping();
        test_table_overflow();
        test_largest_minimum();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
